// ===== rtl/core/json_token_lexer_defines.svh =====
// Assertion macros for the JSON token lexer RTL.
// Included by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef JSON_TOKEN_LEXER_DEFINES_SVH
`define JSON_TOKEN_LEXER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle property, off while reset is held.
`define JTL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("jtl check failed");
// Cause in this cycle, effect in the next one.
`define JTL_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cause |=> effect) \
        else $error("jtl check failed");
`else
`define JTL_ASSERT(label, prop)
`define JTL_ASSERT_NEXT(label, cause, effect)
`endif
`endif

// ===== rtl/core/jtl_pkg.sv =====
// Types, codes and byte helpers shared by the JSON token lexer.
// No dependencies.
`default_nettype none

package jtl_pkg;

    typedef enum logic [3:0] {
        CLS_LBRACE = 4'd0,
        CLS_RBRACE = 4'd1,
        CLS_LBRACK = 4'd2,
        CLS_RBRACK = 4'd3,
        CLS_QUOTE  = 4'd4,
        CLS_COLON  = 4'd5,
        CLS_COMMA  = 4'd6,
        CLS_WORD   = 4'd7,
        CLS_NUMBER = 4'd8,
        CLS_ERROR  = 4'd9,
        CLS_END    = 4'd10
    } t_jtl_class;

    typedef enum logic [1:0] {
        WC_OTHER = 2'd0,
        WC_TRUE  = 2'd1,
        WC_FALSE = 2'd2,
        WC_NULL  = 2'd3
    } t_jtl_wclass;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUM    = 2'd2,
        MODE_SILENT = 2'd3
    } t_jtl_mode;

    localparam logic [7:0] BYTE_END     = 8'h00;
    localparam logic [7:0] BYTE_NL      = 8'h0A;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_MINUS   = 8'h2D;
    localparam logic [7:0] BYTE_LBRACE  = 8'h7B;
    localparam logic [7:0] BYTE_RBRACE  = 8'h7D;
    localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
    localparam logic [7:0] BYTE_RBRACK  = 8'h5D;
    localparam logic [7:0] BYTE_QUOTE   = 8'h22;
    localparam logic [7:0] BYTE_COLON   = 8'h3A;
    localparam logic [7:0] BYTE_COMMA   = 8'h2C;

    // keyword text, first character in the low byte
    localparam logic [63:0] TEXT_TRUE  = 64'h0000_0000_6575_7274;
    localparam logic [63:0] TEXT_FALSE = 64'h0000_0065_736C_6166;
    localparam logic [63:0] TEXT_NULL  = 64'h0000_0000_6C6C_756E;

    localparam int QDEPTH = 4;

    // one queue entry: an optional closed word/number, then an optional short token
    typedef struct packed {
        logic        has_run;
        logic        run_is_num;
        logic        neg;
        logic [31:0] acc;
        logic [7:0]  len;
        logic [63:0] text;
        logic        has_sym;
        t_jtl_class  sym_class;
        logic [7:0]  bad;
    } t_jtl_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_jtl_qstat;

    typedef struct packed {
        t_jtl_class  cls;
        logic [31:0] num;
        t_jtl_wclass wc;
        logic [7:0]  len;
        logic [63:0] text;
        logic [7:0]  bad;
    } t_jtl_token;

    typedef struct packed {
        logic       hit;
        t_jtl_class cls;
    } t_jtl_sym;

    function automatic logic jtl_is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic jtl_is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic t_jtl_sym jtl_sym_lookup(input logic [7:0] b);
        t_jtl_sym s;
        s.hit = 1'b1;
        case (b)
            BYTE_LBRACE: s.cls = CLS_LBRACE;
            BYTE_RBRACE: s.cls = CLS_RBRACE;
            BYTE_LBRACK: s.cls = CLS_LBRACK;
            BYTE_RBRACK: s.cls = CLS_RBRACK;
            BYTE_QUOTE:  s.cls = CLS_QUOTE;
            BYTE_COLON:  s.cls = CLS_COLON;
            BYTE_COMMA:  s.cls = CLS_COMMA;
            default: begin
                s.hit = 1'b0;
                s.cls = CLS_END;
            end
        endcase
        return s;
    endfunction

    // keyword match uses the full length, so longer words stay plain
    function automatic t_jtl_wclass jtl_word_class(input logic [7:0] len,
                                                   input logic [63:0] text);
        if (len == 8'd4 && text == TEXT_TRUE)
            return WC_TRUE;
        if (len == 8'd5 && text == TEXT_FALSE)
            return WC_FALSE;
        if (len == 8'd4 && text == TEXT_NULL)
            return WC_NULL;
        return WC_OTHER;
    endfunction

    function automatic t_jtl_token jtl_sym_token(input t_jtl_class cls,
                                                 input logic [7:0] bad);
        t_jtl_token t;
        t.cls  = cls;
        t.num  = 32'd0;
        t.wc   = WC_OTHER;
        t.len  = 8'd0;
        t.text = 64'd0;
        t.bad  = bad;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jtl_ifs.sv =====
// Valid/ready channel interfaces of the JSON token lexer: text bytes in, tokens out.
// No dependencies.
`default_nettype none

interface jtl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface jtl_token_if;
    logic               valid;
    logic               ready;
    logic [3:0]         token_class;
    logic signed [31:0] number_value;
    logic [1:0]         word_class;
    logic [7:0]         word_length;
    logic [63:0]        word_text;
    logic [7:0]         bad_byte;

    modport source (output valid, output token_class, output number_value,
                    output word_class, output word_length, output word_text,
                    output bad_byte, input ready);
    modport sink (input valid, input token_class, input number_value,
                  input word_class, input word_length, input word_text,
                  input bad_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jtl_front.sv =====
// Front end: a byte a cycle when the queue has room; tracks open token, pushes entries.
// Depends on jtl_pkg, jtl_ifs and json_token_lexer_defines.svh.
`default_nettype none
`include "json_token_lexer_defines.svh"

module jtl_front
    import jtl_pkg::*;
#(
    parameter int KEPT_CHARS = 8,
    parameter int MAX_RUN    = 255
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    jtl_byte_if.sink    i_text,
    input  t_jtl_qstat  i_qstat,
    output logic        o_push,
    output t_jtl_entry  o_entry
);

    localparam int RUN_W  = $clog2(MAX_RUN + 1);
    localparam int KEPT_W = KEPT_CHARS * 8;

    t_jtl_mode           r_mode, n_mode;
    logic [31:0]         r_acc, n_acc;
    logic                r_neg, n_neg;
    logic [RUN_W-1:0]    r_run, n_run;
    logic [KEPT_W-1:0]   r_kept, n_kept;

    logic                w_accept;
    logic [7:0]          w_b;
    logic                w_let, w_dig, w_minus, w_skip, w_unknown;
    t_jtl_sym            w_sym;
    logic                w_continue;
    t_jtl_mode           w_fresh_mode;
    logic [RUN_W-1:0]    w_run_inc;
    logic [KEPT_W-1:0]   w_kept_ext;
    logic [RUN_W+7:0]    w_run_wide;
    logic [7:0]          w_len8;

    assign i_text.ready = !i_qstat.full;
    assign w_accept     = i_text.valid && i_text.ready;
    assign w_b          = i_text.text_byte;

    assign w_let     = jtl_is_letter(w_b);
    assign w_dig     = jtl_is_digit(w_b);
    assign w_minus   = (w_b == BYTE_MINUS);
    assign w_skip    = (w_b == BYTE_SPACE) || (w_b == BYTE_NL);
    assign w_sym     = jtl_sym_lookup(w_b);
    assign w_unknown = !(w_b == BYTE_END || w_skip || w_sym.hit || w_let || w_dig || w_minus);

    assign w_continue = (r_mode == MODE_WORD && (w_let || w_dig)) ||
                        (r_mode == MODE_NUM && w_dig);

    always_comb begin
        if (w_let)
            w_fresh_mode = MODE_WORD;
        else if (w_minus || w_dig)
            w_fresh_mode = MODE_NUM;
        else if (w_unknown)
            w_fresh_mode = MODE_SILENT;
        else
            w_fresh_mode = MODE_IDLE;
    end

    // append one character to the kept text (first KEPT_CHARS only) and count it up to MAX_RUN
    assign w_run_inc = (r_run < RUN_W'(MAX_RUN)) ? r_run + RUN_W'(1) : r_run;

    always_comb begin
        w_kept_ext = r_kept;
        for (int k = 0; k < KEPT_CHARS; k++) begin
            if (r_run == RUN_W'(k))
                w_kept_ext[k*8 +: 8] = w_b;
        end
    end

    assign w_run_wide = {8'd0, r_run};
    assign w_len8     = (w_run_wide > (RUN_W+8)'(255)) ? 8'hFF : w_run_wide[7:0];

    // next state
    always_comb begin
        n_mode = r_mode;
        if (w_accept) begin
            case (r_mode)
                MODE_SILENT: if (w_b == BYTE_END) n_mode = MODE_IDLE;
                MODE_WORD,
                MODE_NUM:    if (!w_continue) n_mode = w_fresh_mode;
                MODE_IDLE:   n_mode = w_fresh_mode;
                default:     n_mode = MODE_IDLE;
            endcase
        end
    end

    // outputs and run registers
    always_comb begin
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_run  = r_run;
        n_kept = r_kept;
        o_push = 1'b0;

        o_entry.has_run    = (r_mode == MODE_WORD) || (r_mode == MODE_NUM);
        o_entry.run_is_num = (r_mode == MODE_NUM);
        o_entry.neg        = r_neg;
        o_entry.acc        = r_acc;
        o_entry.len        = w_len8;
        o_entry.text       = 64'(r_kept);
        o_entry.has_sym    = 1'b0;
        o_entry.sym_class  = CLS_END;
        o_entry.bad        = 8'd0;

        if (w_accept) begin
            if (r_mode == MODE_SILENT) begin
                if (w_b == BYTE_END) begin
                    o_entry.has_sym = 1'b1;
                    o_push          = 1'b1;
                end
            end else if (w_continue) begin
                n_run  = w_run_inc;
                n_kept = w_kept_ext;
                if (r_mode == MODE_NUM)
                    n_acc = (r_acc << 3) + (r_acc << 1) + 32'(w_b[3:0]);
            end else begin
                // byte lexed afresh, possibly after closing the open run
                if (w_b == BYTE_END) begin
                    o_entry.has_sym = 1'b1;
                end else if (w_sym.hit) begin
                    o_entry.has_sym   = 1'b1;
                    o_entry.sym_class = w_sym.cls;
                end else if (w_let) begin
                    n_acc  = 32'd0;
                    n_neg  = 1'b0;
                    n_run  = RUN_W'(1);
                    n_kept = KEPT_W'(w_b);
                end else if (w_minus || w_dig) begin
                    n_acc  = w_dig ? 32'(w_b[3:0]) : 32'd0;
                    n_neg  = w_minus;
                    n_run  = RUN_W'(1);
                    n_kept = '0;
                end else if (w_unknown) begin
                    o_entry.has_sym   = 1'b1;
                    o_entry.sym_class = CLS_ERROR;
                    o_entry.bad       = w_b;
                end
                o_push = o_entry.has_run || o_entry.has_sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= 32'd0;
            r_neg  <= 1'b0;
            r_run  <= '0;
            r_kept <= '0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_run  <= n_run;
            r_kept <= n_kept;
        end
    end

    // a closed run can only come out of an open word or number
    `JTL_ASSERT(a_run_from_open, (o_push && o_entry.has_run) |-> (r_mode == MODE_WORD || r_mode == MODE_NUM))

endmodule

`default_nettype wire

// ===== rtl/core/jtl_fifo.sv =====
// Short entry queue between the lexer front end and the token formatter.
// Depends on jtl_pkg and json_token_lexer_defines.svh.
`default_nettype none
`include "json_token_lexer_defines.svh"

module jtl_fifo
    import jtl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  t_jtl_entry  i_push_data,
    input  wire         i_pop,
    output t_jtl_qstat  o_stat,
    output t_jtl_entry  o_head
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_jtl_entry        r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_stat.full  = (r_count == CNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop)
            n_count = r_count + CNT_W'(1);
        else if (!i_push && i_pop)
            n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `JTL_ASSERT(a_count_bound, r_count <= CNT_W'(QDEPTH))

endmodule

`default_nettype wire

// ===== rtl/core/jtl_back.sv =====
// Token formatter: pops queue entries, builds tokens, drives the output register.
// Depends on jtl_pkg, jtl_ifs and json_token_lexer_defines.svh.
`default_nettype none
`include "json_token_lexer_defines.svh"

module jtl_back
    import jtl_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_jtl_qstat   i_qstat,
    input  t_jtl_entry   i_head,
    output logic         o_pop,
    jtl_token_if.source  o_token
);

    logic        r_out_valid, n_out_valid;
    t_jtl_token  r_out, n_out;
    logic        r_pend_valid, n_pend_valid;
    t_jtl_class  r_pend_cls, n_pend_cls;
    logic [7:0]  r_pend_bad, n_pend_bad;

    logic        w_free;
    t_jtl_token  w_run_tok;

    assign w_free = !r_out_valid || o_token.ready;
    assign o_pop  = w_free && !r_pend_valid && !i_qstat.empty;

    // closed word or number token
    always_comb begin
        w_run_tok.bad = 8'd0;
        w_run_tok.len = i_head.len;
        if (i_head.run_is_num) begin
            w_run_tok.cls  = CLS_NUMBER;
            w_run_tok.num  = i_head.neg ? 32'd0 - i_head.acc : i_head.acc;
            w_run_tok.wc   = WC_OTHER;
            w_run_tok.text = 64'd0;
        end else begin
            w_run_tok.cls  = CLS_WORD;
            w_run_tok.num  = 32'd0;
            w_run_tok.wc   = jtl_word_class(i_head.len, i_head.text);
            w_run_tok.text = i_head.text;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend_cls   = r_pend_cls;
        n_pend_bad   = r_pend_bad;
        if (w_free) begin
            if (r_pend_valid) begin
                n_out        = jtl_sym_token(r_pend_cls, r_pend_bad);
                n_out_valid  = 1'b1;
                n_pend_valid = 1'b0;
            end else if (o_pop) begin
                n_out_valid = 1'b1;
                if (i_head.has_run) begin
                    n_out        = w_run_tok;
                    n_pend_valid = i_head.has_sym;
                    n_pend_cls   = i_head.sym_class;
                    n_pend_bad   = i_head.bad;
                end else begin
                    n_out = jtl_sym_token(i_head.sym_class, i_head.bad);
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pend_cls <= n_pend_cls;
        r_pend_bad <= n_pend_bad;
    end

    assign o_token.valid        = r_out_valid;
    assign o_token.token_class  = r_out.cls;
    assign o_token.number_value = $signed(r_out.num);
    assign o_token.word_class   = r_out.wc;
    assign o_token.word_length  = r_out.len;
    assign o_token.word_text    = r_out.text;
    assign o_token.bad_byte     = r_out.bad;

    // a held second token always sits behind a shown first one
    `JTL_ASSERT(a_pend_behind_out, r_pend_valid |-> r_out_valid)
    // every entry popped carries at least one token
    `JTL_ASSERT(a_pop_has_token, o_pop |-> (i_head.has_run || i_head.has_sym))
    // a stalled pair keeps its second token
    `JTL_ASSERT_NEXT(a_pend_kept, (r_pend_valid && !o_token.ready), r_pend_valid)

endmodule

`default_nettype wire

// ===== rtl/core/json_token_lexer.sv =====
// JSON token lexer top level: front end, entry queue and token formatter.
// Depends on jtl_pkg, jtl_ifs, jtl_front, jtl_fifo and jtl_back.
`default_nettype none

// Byte-serial lexer for JSON-like text. One text byte is taken per clock on
// i_text while the queue is not full; tokens leave one per clock on o_token
// while the receiver is ready. Space and newline are dropped, { } [ ] " : ,
// give symbol tokens, letters open a word token, a minus or digit opens a
// number token, a zero byte gives an end token (after any open token), and
// any other byte gives an error token after which input is swallowed until
// the zero byte. The front end classifies each accepted byte and writes at
// most one queue entry; the entry can hold a closed word/number plus the token
// of the byte that closed it. The formatter turns an entry into one or two
// tokens, one per output cycle. An entry with two tokens always follows at
// least one byte that wrote no entry, so with the receiver ready the output
// keeps pace and input runs at one byte per cycle; the 4-entry queue fills and
// input stops only while the receiver holds off. Tokens pass from the queue
// through the output register, a pair's second token also through a pending
// register. No clearing pass after reset: ready as soon as reset is released.

module json_token_lexer
    import jtl_pkg::*;
#(
    parameter int KEPT_CHARS = 8,    // word characters kept in word_text, 5..8
    parameter int MAX_RUN    = 255   // run length counter saturation, 8..65535
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    jtl_byte_if.sink     i_text,
    jtl_token_if.source  o_token
);

    // front end -> queue
    logic        w_push;
    t_jtl_entry  w_push_data;

    // queue -> formatter
    logic        w_pop;
    t_jtl_qstat  w_qstat;
    t_jtl_entry  w_head;

    jtl_front #(
        .KEPT_CHARS (KEPT_CHARS),
        .MAX_RUN    (MAX_RUN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_push_data)
    );

    jtl_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_stat      (w_qstat),
        .o_head      (w_head)
    );

    jtl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_token (o_token)
    );

endmodule

`default_nettype wire
